@@ src/cdb_pkg.sv @@
// cdb_pkg: shared types and constants for the circular deque buffer
// no dependencies; imported by circular_deque_buffer and tb_circular_deque_buffer
package cdb_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_W     = 9;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_NOP        = 3'd4
    } op_t;

endpackage

@@ src/circular_deque_buffer.sv @@
// circular_deque_buffer: bounded double-ended queue of 32-bit words in a ring memory
// depends on cdb_pkg
// a request waits in the request register, then its result in the result register
// throughput: one request per cycle unless res_stall holds a result; head/occupancy
//   update and both ring reads (front/rear, write bypass) share a single exec stage
// reset: head, occupancy and valid flags cleared, capacity set to 256;
//   the ring memory is not cleared, only written entries are ever read
module circular_deque_buffer
    import cdb_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,

    input  logic                      op_valid,
    output logic                      op_stall,
    input  logic [2:0]                operation,
    input  logic signed [DATA_W-1:0]  value,

    output logic                      res_valid,
    input  logic                      res_stall,
    output logic                      success,
    output logic signed [DATA_W-1:0]  front_value,
    output logic signed [DATA_W-1:0]  rear_value,
    output logic                      is_empty,
    output logic                      is_full
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [AW-1:0]   LAST_POS  = AW'(DEPTH - 1);
    localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(DEPTH);

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= (AW+1)'(DEPTH))
            begin
                s = s - (AW+1)'(DEPTH);
            end
            return s[AW-1:0];
        end
    endfunction

    // configuration
    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_wr;

    // control state
    logic [AW-1:0]    head_reg;
    logic [CW-1:0]    occ_reg;
    logic             in_valid_reg;
    logic             res_valid_reg;

    // request register
    op_t              op_reg;
    logic [DATA_W-1:0] value_reg;

    // result register
    logic             success_reg;
    logic             empty_reg;
    logic             full_reg;
    logic [DATA_W-1:0] front_reg;
    logic [DATA_W-1:0] rear_reg;

    logic [DATA_W-1:0] ring_mem [DEPTH];

    // exec stage signals
    logic             adv;
    logic             exec;
    logic             in_load;
    logic [CMPW-1:0]  cap_eff;
    logic             full_now;
    logic             empty_now;
    logic             ok;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    head_next;
    logic [CW-1:0]    occ_next;
    logic             empty_next;
    logic             full_next;
    logic [AW-1:0]    front_addr;
    logic [AW-1:0]    rear_addr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // ---------------- handshake ----------------
    assign adv      = !res_valid_reg || !res_stall;
    assign exec     = adv && in_valid_reg;
    assign in_load  = !in_valid_reg || adv;
    assign op_stall = in_valid_reg && !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= op_valid;
            end
            if (adv)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && op_valid)
        begin
            // codes above the defined set behave as no change
            op_reg    <= (operation > OP_NOP) ? OP_NOP : op_t'(operation);
            value_reg <= value;
        end
    end

    // ---------------- exec logic ----------------
    always_comb
    begin
        cap_eff   = (CMPW'(capacity_reg) > DEPTH_CMP) ? DEPTH_CMP : CMPW'(capacity_reg);
        full_now  = CMPW'(occ_reg) >= cap_eff;
        empty_now = (occ_reg == '0);

        ok        = 1'b1;
        we        = 1'b0;
        waddr     = ring_add(head_reg, AW'(occ_reg));
        head_next = head_reg;
        occ_next  = occ_reg;

        unique case (op_reg)
            OP_PUSH_FRONT:
            begin
                if (full_now)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    head_next = (head_reg == '0) ? LAST_POS : head_reg - 1'b1;
                    waddr     = head_next;
                    we        = 1'b1;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            OP_PUSH_REAR:
            begin
                if (full_now)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    we       = 1'b1;
                    occ_next = occ_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty_now)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    head_next = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
                    occ_next  = occ_reg - 1'b1;
                end
            end
            OP_POP_REAR:
            begin
                if (empty_now)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    occ_next = occ_reg - 1'b1;
                end
            end
            default:
            begin
                ok = 1'b1;
            end
        endcase

        empty_next = (occ_next == '0);
        full_next  = CMPW'(occ_next) >= cap_eff;
        front_addr = head_next;
        rear_addr  = ring_add(head_next, AW'(occ_next - 1'b1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
        end
        else if (exec)
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

    // ring memory with registered reads; bypass the word written this cycle
    always_ff @(posedge clk)
    begin
        if (exec && we)
        begin
            ring_mem[waddr] <= value_reg;
        end
        if (adv)
        begin
            success_reg <= ok;
            empty_reg   <= empty_next;
            full_reg    <= full_next;
            if (empty_next)
            begin
                front_reg <= '1;
                rear_reg  <= '1;
            end
            else
            begin
                front_reg <= (we && waddr == front_addr) ? value_reg : ring_mem[front_addr];
                rear_reg  <= (we && waddr == rear_addr) ? value_reg : ring_mem[rear_addr];
            end
        end
    end

    assign res_valid   = res_valid_reg;
    assign success     = success_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;
    assign front_value = front_reg;
    assign rear_value  = rear_reg;

    // ---------------- assertions ----------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(occ_reg) <= CW'(DEPTH))
        else $error("occupancy above store depth");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (occ_reg == $past(occ_reg) || occ_reg == $past(occ_reg) + 1'b1 ||
                  occ_reg == $past(occ_reg) - 1'b1))
        else $error("occupancy moved by more than one");

    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && !ok) |=> (occ_reg == $past(occ_reg) && head_reg == $past(head_reg)))
        else $error("failed request changed deque state");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (empty_reg == (occ_reg == '0)) || !$past(exec))
        else $error("empty flag does not match occupancy");

endmodule

@@ bench/tb_circular_deque_buffer.sv @@
// tb_circular_deque_buffer: self-checking bench for the circular deque buffer
// runs directed and random requests under random idle and stall, checks every result
// depends on cdb_pkg and circular_deque_buffer
module tb_circular_deque_buffer;
    import cdb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH  = 256;
    localparam int HEAD_W = $clog2(DEPTH);

    // operation codes the block treats as no change
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'({REG_CAPACITY, 2'b00});

    typedef struct {
        logic [2:0]        op;
        logic [DATA_W-1:0] word;
    } deque_request_t;

    typedef struct {
        logic              success;
        logic [DATA_W-1:0] front;
        logic [DATA_W-1:0] rear;
        logic              empty;
        logic              full;
    } deque_status_t;

    typedef enum int {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY, DRAIN_ALTERNATE} drain_mode_t;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      psel     = 1'b0;
    logic                      penable  = 1'b0;
    logic                      pwrite   = 1'b0;
    logic [PADDR_W-1:0]        paddr    = '0;
    logic [PDATA_W-1:0]        pwdata   = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      op_valid  = 1'b0;
    logic                      op_stall;
    logic [2:0]                operation = OP_NOP;
    logic signed [DATA_W-1:0]  value     = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    logic                      success;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  rear_value;
    logic                      is_empty;
    logic                      is_full;

    // shadow copy of the deque state
    logic [DATA_W-1:0] shadow_store [DEPTH];
    logic [HEAD_W-1:0] shadow_head     = '0;
    logic [CAP_W-1:0]  shadow_count    = '0;
    logic [CAP_W-1:0]  shadow_capacity = CAP_RESET;

    deque_request_t op_requests [$];
    deque_status_t  deque_outcome_q [$];

    int          error_count = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    drain_mode_t drain_mode  = DRAIN_FREE;
    int          drain_left  = 0;

    circular_deque_buffer #(.DEPTH(DEPTH)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .op_valid   (op_valid),
        .op_stall   (op_stall),
        .operation  (operation),
        .value      (value),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .success    (success),
        .front_value(front_value),
        .rear_value (rear_value),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic deque_status_t step_shadow_deque(logic [2:0] op, logic [DATA_W-1:0] word);
        deque_status_t st;
        int            limit;
        logic          full_now;
        logic          empty_now;
        limit     = (shadow_capacity > DEPTH) ? DEPTH : int'(shadow_capacity);
        full_now  = int'(shadow_count) >= limit;
        empty_now = shadow_count == 0;
        st.success = 1'b1;
        unique case (op)
            OP_PUSH_FRONT:
                if (full_now)
                    st.success = 1'b0;
                else
                begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_store[shadow_head] = word;
                    shadow_count = shadow_count + 1'b1;
                end
            OP_PUSH_REAR:
                if (full_now)
                    st.success = 1'b0;
                else
                begin
                    shadow_store[HEAD_W'(shadow_head + shadow_count)] = word;
                    shadow_count = shadow_count + 1'b1;
                end
            OP_POP_FRONT:
                if (empty_now)
                    st.success = 1'b0;
                else
                begin
                    shadow_head = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            OP_POP_REAR:
                if (empty_now)
                    st.success = 1'b0;
                else
                    shadow_count = shadow_count - 1'b1;
            default:
                ;
        endcase
        st.empty = shadow_count == 0;
        st.full  = int'(shadow_count) >= limit;
        if (st.empty)
        begin
            st.front = '1;
            st.rear  = '1;
        end
        else
        begin
            st.front = shadow_store[shadow_head];
            st.rear  = shadow_store[HEAD_W'(shadow_head + shadow_count - 1'b1)];
        end
        return st;
    endfunction

    task automatic note_error(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        error_count++;
        if (error_count <= 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // request driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid  <= 1'b0;
            operation <= OP_NOP;
            value     <= '0;
        end
        else if (!(op_valid && op_stall))
        begin
            if (op_valid)
                deque_outcome_q.insert(deque_outcome_q.size(),
                                       step_shadow_deque(operation, value));
            if (gap_left > 0)
            begin
                gap_left--;
                op_valid <= 1'b0;
            end
            else if (op_requests.size() != 0)
            begin
                deque_request_t req;
                req = op_requests.pop_front();
                op_valid  <= 1'b1;
                operation <= req.op;
                value     <= req.word;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                              : $urandom_range(0, 20);
                end
            end
            else
                op_valid <= 1'b0;
        end
    end

    // result checker with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (deque_outcome_q.size() == 0)
                    note_error("result with no request outstanding", '0, '0);
                else
                begin
                    deque_status_t want;
                    want = deque_outcome_q.pop_front();
                    if (success !== want.success)
                        note_error("success", DATA_W'(want.success), DATA_W'(success));
                    if (front_value !== want.front)
                        note_error("front_value", want.front, front_value);
                    if (rear_value !== want.rear)
                        note_error("rear_value", want.rear, rear_value);
                    if (is_empty !== want.empty)
                        note_error("is_empty", DATA_W'(want.empty), DATA_W'(is_empty));
                    if (is_full !== want.full)
                        note_error("is_full", DATA_W'(want.full), DATA_W'(is_full));
                end
            end
            if (drain_left == 0)
            begin
                drain_mode = drain_mode_t'($urandom_range(0, 3));
                drain_left = $urandom_range(10, 80);
            end
            else
                drain_left--;
            unique case (drain_mode)
                DRAIN_FREE:      res_stall <= 1'b0;
                DRAIN_LIGHT:     res_stall <= $urandom_range(0, 3) == 0;
                DRAIN_HEAVY:     res_stall <= $urandom_range(0, 3) != 0;
                DRAIN_ALTERNATE: res_stall <= !res_stall;
                default:         res_stall <= 1'b0;
            endcase
        end
    end

    task automatic add_request(logic [2:0] op, logic [DATA_W-1:0] word);
        deque_request_t req;
        req.op   = op;
        req.word = word;
        op_requests.insert(op_requests.size(), req);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        unique case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // waits until every request has been sent and answered
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (op_requests.size() != 0 || op_valid || deque_outcome_q.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= PDATA_W'(cap);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_capacity = cap;
        @(negedge clk);
    endtask

    // push-heavy and pop-heavy runs so that full and empty are both reached
    task automatic queue_random_phase(int count);
        int         limit;
        int         run_left;
        bit         filling;
        int         roll;
        logic [2:0] op;
        logic [2:0] push_op;
        logic [2:0] pop_op;
        limit    = (shadow_capacity > DEPTH) ? DEPTH : int'(shadow_capacity);
        filling  = 1'b1;
        run_left = limit + limit / 2 + 4;
        for (int i = 0; i < count; i++)
        begin
            if (run_left == 0)
            begin
                filling  = 1'($urandom_range(0, 1));
                run_left = $urandom_range(1, 2 * limit + 8);
            end
            run_left--;
            push_op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            pop_op  = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
            roll = $urandom_range(0, 99);
            if (roll < 6)
                op = $urandom_range(0, 1) ? OP_NOP
                                          : 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            else if (roll < 86)
                op = filling ? push_op : pop_op;
            else
                op = filling ? pop_op : push_op;
            add_request(op, pick_word());
        end
    endtask

    initial
    begin
        int phase_cap [10] = '{256, 4, 1, 0, 511, 17, 2, 256, 100, 8};
        int phase_len [10] = '{450, 100, 100, 60, 450, 150, 100, 300, 150, 100};
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty deque, extreme words, spare codes, head wrap on first front push
        add_request(OP_POP_FRONT, '0);
        add_request(OP_POP_REAR, '1);
        add_request(OP_NOP, 32'h7fff_ffff);
        add_request(OP_PUSH_FRONT, 32'h7fff_ffff);
        add_request(OP_PUSH_REAR, 32'h8000_0000);
        add_request(OP_PUSH_FRONT, '1);
        add_request(OP_PUSH_REAR, '0);
        add_request(OP_SPARE_LO, 32'h1234_5678);
        add_request(OP_SPARE_LO + 3'd1, 32'h8765_4321);
        add_request(OP_SPARE_HI, '1);
        add_request(OP_POP_FRONT, '0);
        add_request(OP_POP_REAR, '0);
        add_request(OP_POP_FRONT, '0);
        add_request(OP_POP_REAR, '0);
        add_request(OP_POP_REAR, '0);
        add_request(OP_PUSH_REAR, 32'h5555_5555);
        add_request(OP_PUSH_FRONT, 32'haaaa_aaaa);
        wait_for_drain();

        // capacity lowered below the occupancy, then capacity of one
        write_capacity(9'd1);
        add_request(OP_PUSH_REAR, 32'h0bad_cafe);
        add_request(OP_POP_FRONT, '0);
        add_request(OP_POP_REAR, '0);
        add_request(OP_PUSH_FRONT, 32'hdead_beef);
        add_request(OP_PUSH_REAR, 32'h0000_0001);
        add_request(OP_POP_REAR, '0);
        wait_for_drain();

        // zero capacity: empty and full at once
        write_capacity(9'd0);
        add_request(OP_PUSH_FRONT, 32'h0000_0002);
        add_request(OP_PUSH_REAR, 32'h0000_0003);
        add_request(OP_POP_FRONT, '0);
        wait_for_drain();

        for (int p = 0; p < 10; p++)
        begin
            write_capacity(CAP_W'(phase_cap[p]));
            queue_random_phase(phase_len[p]);
            wait_for_drain();
        end

        repeat (5) @(negedge clk);
        if (error_count == 0 && deque_outcome_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
src/cdb_pkg.sv
src/circular_deque_buffer.sv
bench/tb_circular_deque_buffer.sv
